FILE: sv/date_day_count_converter_core_defines.svh
// ----------------------------------------------------------------------------
// Date day count converter: assertion macros
// Shared assertion forms for the converter core.
// ----------------------------------------------------------------------------
`ifndef DATE_DAY_COUNT_CONVERTER_CORE_DEFINES_SVH
`define DATE_DAY_COUNT_CONVERTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication that stays active through reset.
`define DDC_ASSERT_NXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ddc_pkg.sv
// ----------------------------------------------------------------------------
// ddc_pkg
// Types, constants and calendar functions for the date day count converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddc_pkg;

    localparam int unsigned EPOCH_YEAR     = 1970;
    localparam int unsigned LAST_YEAR      = 2038;
    localparam int unsigned NUM_MONTHS     = 12;
    localparam int unsigned COUNT_BITS_DEF = 16;

    // 2100 is the only year in reach that breaks the four-year leap rule.
    localparam int unsigned LEAP_SKIP_OFF  = 2100 - EPOCH_YEAR;
    localparam int unsigned LEAP_PHASE     = 2;

    // Year estimate: offset ~= count * EST_MUL >> EST_SHIFT, which is at most
    // one year low and never high over the whole 16-bit count range.
    localparam int unsigned EST_MUL        = 2870;
    localparam int unsigned EST_W          = 12;
    localparam int unsigned EST_SHIFT      = 20;

    localparam int unsigned YEAR_W         = 14;
    localparam int unsigned MD_W           = 7;
    localparam int unsigned CNT_W          = 16;
    localparam int unsigned YOFF_W         = 8;
    localparam int unsigned YS_W           = 17;
    localparam int unsigned REM_W          = 9;
    localparam int unsigned YEAR_OUT_W     = 12;
    localparam int unsigned MONTH_W        = 4;
    localparam int unsigned DAY_W          = 5;

    typedef enum logic {
        MODE_TO_COUNT = 1'b0,
        MODE_TO_DATE  = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode                    mode;
        logic                     ok;
        logic [YOFF_W-1:0]        yoff;
        logic                     leap;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
        logic [CNT_W-1:0]         cnt;
    } t_chk;

    typedef struct packed {
        t_mode                    mode;
        logic                     ok;
        logic [YS_W-1:0]          ystart0;
        logic [YS_W-1:0]          ystart1;
        logic [REM_W-1:0]         mdays;
        logic [YOFF_W-1:0]        yoff;
        logic [CNT_W-1:0]         cnt;
    } t_yst;

    typedef struct packed {
        t_mode                    mode;
        logic                     ok;
        logic [CNT_W-1:0]         total;
        logic [YOFF_W-1:0]        yoff;
        logic [REM_W-1:0]         rem;
    } t_ysel;

    typedef struct packed {
        t_mode                    mode;
        logic                     ok;
        logic [CNT_W-1:0]         total;
        logic [YOFF_W-1:0]        yoff;
        logic [REM_W-1:0]         rem;
        logic [MONTH_W-1:0]       month;
        logic [REM_W-1:0]         mstart;
    } t_msel;

    typedef struct packed {
        logic                     valid_res;
        logic [CNT_W-1:0]         days_out;
        logic [YEAR_OUT_W-1:0]    year_out;
        logic [MONTH_W-1:0]       month_out;
        logic [DAY_W-1:0]         day_out;
    } t_res;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:                                       n = leap ? 5'd29 : 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

    // Days in the year before the first of month m.
    function automatic logic [REM_W-1:0] month_start(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [REM_W-1:0] s;
        case (m)
            4'd1:    s = 9'd0;
            4'd2:    s = 9'd31;
            4'd3:    s = 9'd59;
            4'd4:    s = 9'd90;
            4'd5:    s = 9'd120;
            4'd6:    s = 9'd151;
            4'd7:    s = 9'd181;
            4'd8:    s = 9'd212;
            4'd9:    s = 9'd243;
            4'd10:   s = 9'd273;
            4'd11:   s = 9'd304;
            4'd12:   s = 9'd334;
            default: s = 9'd0;
        endcase
        if (leap && (m > 4'd2)) begin
            s = s + 9'd1;
        end
        return s;
    endfunction

    // Day count of January 1 of the year EPOCH_YEAR + k.
    function automatic logic [YS_W-1:0] year_start(input logic [YOFF_W-1:0] k);
        logic [YOFF_W-1:0] kp1;
        logic [YS_W-1:0]   base;
        kp1  = k + 8'd1;
        base = YS_W'(k) * YS_W'(365);
        base = base + YS_W'(kp1 >> 2);
        if (k > YOFF_W'(LEAP_SKIP_OFF)) begin
            base = base - YS_W'(1);
        end
        return base;
    endfunction

    function automatic logic year_is_leap(input logic [YOFF_W-1:0] k);
        return (k[1:0] == 2'(LEAP_PHASE)) && (k != YOFF_W'(LEAP_SKIP_OFF));
    endfunction

endpackage

FILE: sv/date_day_count_converter_core.sv
// ----------------------------------------------------------------------------
// date_day_count_converter_core
// Converts between Gregorian dates and day counts since 1970-01-01. The
// slave channel takes one transaction per item: tuser carries the mode, tdata
// the date and the day count. With mode 0 the date is checked (years 1970 to
// 2038, real months and month lengths with leap Februaries) and its day count
// returned; with mode 1 the day count is turned into year, month and day.
// The master channel returns one transaction per item, in order; tuser is the
// valid flag. Fields that do not belong to the mode are zero.
// Five register stages lead from an accepted input to the master channel:
// check and estimate, year start lookup, year correction, month search,
// output register. Throughput is one transaction per cycle unless the
// receiver stalls. Each stage holds its item until the next one frees, so
// when the receiver stalls the pipeline keeps filling its empty stages and
// lowers tready only once all five are full; nothing is lost or repeated.
// Reset clears all valid bits; the block is ready in the first cycle after.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "date_day_count_converter_core_defines.svh"

module date_day_count_converter_core #(
    parameter int COUNT_BITS = ddc_pkg::COUNT_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // year[13:0], month[20:14], day[27:21], day_count[43:28], zero[47:44]
    input  logic [47:0]  i_s_axis_tdata,
    // mode[0]
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // days_out[15:0], year_out[27:16], month_out[31:28], day_out[36:32], zero[39:37]
    output logic [39:0]  o_m_axis_tdata,
    // valid_res[0]
    output logic         o_m_axis_tuser
);

    // Stage handshakes: each stage accepts when it is empty or when the
    // stage after it is taking its item in the same cycle.
    logic               w_chk_valid;
    logic               w_chk_ready;
    ddc_pkg::t_chk      w_chk;
    logic               w_yr_valid;
    logic               w_yr_ready;
    ddc_pkg::t_ysel     w_yr;
    ddc_pkg::t_res      w_res;

    // The first stage validates a mode 0 date and, for mode 1, estimates the
    // year offset from the day count with one constant multiplication.
    ddc_check #(
        .COUNT_BITS (COUNT_BITS)
    ) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_mode      (ddc_pkg::t_mode'(i_s_axis_tuser)),
        .i_year      (i_s_axis_tdata[13:0]),
        .i_month     (i_s_axis_tdata[20:14]),
        .i_day       (i_s_axis_tdata[27:21]),
        .i_day_count (i_s_axis_tdata[43:28]),
        .o_valid     (w_chk_valid),
        .i_ready     (w_chk_ready),
        .o_stage     (w_chk)
    );

    // Year start lookup, then the estimate is corrected by at most one year
    // and the remainder within the year is formed. Mode 0 sums its total here.
    ddc_year u_year (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_chk_valid),
        .o_ready (w_chk_ready),
        .i_stage (w_chk),
        .o_valid (w_yr_valid),
        .i_ready (w_yr_ready),
        .o_stage (w_yr)
    );

    // Month search over the cumulative month starts, then the output register.
    ddc_month u_month (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_yr_valid),
        .o_ready (w_yr_ready),
        .i_stage (w_yr),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (w_res)
    );

    assign o_m_axis_tdata = {3'b000, w_res.day_out, w_res.month_out,
                             w_res.year_out, w_res.days_out};
    assign o_m_axis_tuser = w_res.valid_res;

    // Input backpressure can only come from a stalled output.
    `DDC_ASSERT_IMP(a_stall_from_output, i_clk, i_rst_n,
        !o_s_axis_tready, o_m_axis_tvalid && !i_m_axis_tready,
        "input stalled while output is free")

    // Reset empties every stage.
    `DDC_ASSERT_NXT(a_reset_empty, i_clk, !i_rst_n,
        !o_m_axis_tvalid && o_s_axis_tready,
        "pipeline not empty after reset")

    // A rejected date produces an all-zero result.
    `DDC_ASSERT_IMP(a_invalid_zero, i_clk, i_rst_n,
        o_m_axis_tvalid && !o_m_axis_tuser, o_m_axis_tdata == 40'd0,
        "invalid result carries nonzero fields")

    // A decoded date is flagged valid, has month 1 to 12 and a nonzero day, and no count.
    `DDC_ASSERT_IMP(a_date_range, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tdata[27:16] != 12'd0),
        o_m_axis_tuser && (o_m_axis_tdata[15:0] == 16'd0) &&
        (o_m_axis_tdata[31:28] >= 4'd1) && (o_m_axis_tdata[31:28] <= 4'd12) &&
        (o_m_axis_tdata[36:32] >= 5'd1),
        "decoded date out of range")

endmodule

FILE: sv/ddc_check.sv
// ----------------------------------------------------------------------------
// ddc_check
// Input stage: date validation and year estimate for a day count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddc_check #(
    parameter int COUNT_BITS = ddc_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  ddc_pkg::t_mode                      i_mode,
    input  logic [ddc_pkg::YEAR_W-1:0]          i_year,
    input  logic [ddc_pkg::MD_W-1:0]            i_month,
    input  logic [ddc_pkg::MD_W-1:0]            i_day,
    input  logic [ddc_pkg::CNT_W-1:0]           i_day_count,
    output logic                                o_valid,
    input  logic                                i_ready,
    output ddc_pkg::t_chk                       o_stage
);

    localparam int CntW = (COUNT_BITS < int'(ddc_pkg::CNT_W)) ? COUNT_BITS
                                                              : int'(ddc_pkg::CNT_W);
    localparam int ProdW = ddc_pkg::CNT_W + ddc_pkg::EST_W;

    logic                                r_vld;
    ddc_pkg::t_chk                       r_stage;
    ddc_pkg::t_chk                       n_stage;
    logic                                w_ready;
    logic [ddc_pkg::YOFF_W-1:0]          w_yoff;
    logic                                w_leap;
    logic [ddc_pkg::DAY_W-1:0]           w_mlen;
    logic                                w_year_ok;
    logic                                w_month_ok;
    logic                                w_day_ok;
    logic [ddc_pkg::CNT_W-1:0]           w_cnt;
    logic [ProdW-1:0]                    w_prod;

    assign w_ready = !r_vld || i_ready;
    assign o_ready = w_ready;
    assign o_valid = r_vld;
    assign o_stage = r_stage;

    always_comb begin
        w_year_ok  = (i_year >= ddc_pkg::YEAR_W'(ddc_pkg::EPOCH_YEAR)) &&
                     (i_year <= ddc_pkg::YEAR_W'(ddc_pkg::LAST_YEAR));
        w_yoff     = ddc_pkg::YOFF_W'(i_year - ddc_pkg::YEAR_W'(ddc_pkg::EPOCH_YEAR));
        w_leap     = ddc_pkg::year_is_leap(w_yoff);
        w_month_ok = (i_month >= ddc_pkg::MD_W'(1)) &&
                     (i_month <= ddc_pkg::MD_W'(ddc_pkg::NUM_MONTHS));
        w_mlen     = ddc_pkg::month_len(i_month[ddc_pkg::MONTH_W-1:0], w_leap);
        w_day_ok   = (i_day != ddc_pkg::MD_W'(0)) && (i_day <= ddc_pkg::MD_W'(w_mlen));
        w_cnt      = ddc_pkg::CNT_W'(i_day_count[CntW-1:0]);
        w_prod     = ProdW'(w_cnt) * ProdW'(ddc_pkg::EST_MUL);

        n_stage.mode  = i_mode;
        n_stage.ok    = (i_mode == ddc_pkg::MODE_TO_COUNT) &&
                        w_year_ok && w_month_ok && w_day_ok;
        n_stage.yoff  = (i_mode == ddc_pkg::MODE_TO_DATE) ?
                        w_prod[ddc_pkg::EST_SHIFT +: ddc_pkg::YOFF_W] : w_yoff;
        n_stage.leap  = w_leap;
        n_stage.month = i_month[ddc_pkg::MONTH_W-1:0];
        n_stage.day   = i_day[ddc_pkg::DAY_W-1:0];
        n_stage.cnt   = w_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_stage <= n_stage;
        end
    end

endmodule

FILE: sv/ddc_year.sv
// ----------------------------------------------------------------------------
// ddc_year
// Year start lookup and year correction, two register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddc_year (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  ddc_pkg::t_chk         i_stage,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ddc_pkg::t_ysel        o_stage
);

    logic                         r_vld_a;
    logic                         r_vld_b;
    ddc_pkg::t_yst                r_a;
    ddc_pkg::t_yst                n_a;
    ddc_pkg::t_ysel               r_b;
    ddc_pkg::t_ysel               n_b;
    logic                         w_ready_a;
    logic                         w_ready_b;
    logic [ddc_pkg::YS_W:0]       w_diff1;
    logic                         w_take1;

    assign w_ready_b = !r_vld_b || i_ready;
    assign w_ready_a = !r_vld_a || w_ready_b;
    assign o_ready   = w_ready_a;
    assign o_valid   = r_vld_b;
    assign o_stage   = r_b;

    // Both neighboring year starts are fetched; the next stage picks one.
    always_comb begin
        n_a.mode    = i_stage.mode;
        n_a.ok      = i_stage.ok;
        n_a.ystart0 = ddc_pkg::year_start(i_stage.yoff);
        n_a.ystart1 = ddc_pkg::year_start(i_stage.yoff + ddc_pkg::YOFF_W'(1));
        n_a.mdays   = ddc_pkg::month_start(i_stage.month, i_stage.leap) +
                      ddc_pkg::REM_W'(i_stage.day) - ddc_pkg::REM_W'(1);
        n_a.yoff    = i_stage.yoff;
        n_a.cnt     = i_stage.cnt;
    end

    always_comb begin
        w_diff1 = (ddc_pkg::YS_W + 1)'(r_a.cnt) - (ddc_pkg::YS_W + 1)'(r_a.ystart1);
        w_take1 = !w_diff1[ddc_pkg::YS_W];

        n_b.mode  = r_a.mode;
        n_b.ok    = r_a.ok;
        n_b.total = r_a.ystart0[ddc_pkg::CNT_W-1:0] + ddc_pkg::CNT_W'(r_a.mdays);
        n_b.yoff  = r_a.yoff + ddc_pkg::YOFF_W'(w_take1);
        n_b.rem   = w_take1 ? w_diff1[ddc_pkg::REM_W-1:0] :
                    (r_a.cnt[ddc_pkg::REM_W-1:0] - r_a.ystart0[ddc_pkg::REM_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (w_ready_a) begin
                r_vld_a <= i_valid;
            end
            if (w_ready_b) begin
                r_vld_b <= r_vld_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_valid) begin
            r_a <= n_a;
        end
        if (w_ready_b && r_vld_a) begin
            r_b <= n_b;
        end
    end

endmodule

FILE: sv/ddc_month.sv
// ----------------------------------------------------------------------------
// ddc_month
// Month search and result formatting, two register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddc_month (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  ddc_pkg::t_ysel        i_stage,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ddc_pkg::t_res         o_res
);

    logic                              r_vld_a;
    logic                              r_vld_b;
    ddc_pkg::t_msel                    r_a;
    ddc_pkg::t_msel                    n_a;
    ddc_pkg::t_res                     r_b;
    ddc_pkg::t_res                     n_b;
    logic                              w_ready_a;
    logic                              w_ready_b;
    logic                              w_leap;
    logic [ddc_pkg::REM_W-1:0]         w_ms;

    assign w_ready_b = !r_vld_b || i_ready;
    assign w_ready_a = !r_vld_a || w_ready_b;
    assign o_ready   = w_ready_a;
    assign o_valid   = r_vld_b;
    assign o_res     = r_b;

    // The latest month whose first day is not past the remainder wins.
    always_comb begin
        w_leap    = ddc_pkg::year_is_leap(i_stage.yoff);
        n_a.mode  = i_stage.mode;
        n_a.ok    = i_stage.ok;
        n_a.total = i_stage.total;
        n_a.yoff  = i_stage.yoff;
        n_a.rem   = i_stage.rem;
        n_a.month = ddc_pkg::MONTH_W'(1);
        n_a.mstart = ddc_pkg::REM_W'(0);
        w_ms      = ddc_pkg::REM_W'(0);
        for (int i = 2; i <= int'(ddc_pkg::NUM_MONTHS); i++) begin
            w_ms = ddc_pkg::month_start(ddc_pkg::MONTH_W'(i), w_leap);
            if (i_stage.rem >= w_ms) begin
                n_a.month  = ddc_pkg::MONTH_W'(i);
                n_a.mstart = w_ms;
            end
        end
    end

    always_comb begin
        n_b = '0;
        if (r_a.mode == ddc_pkg::MODE_TO_DATE) begin
            n_b.valid_res = 1'b1;
            n_b.year_out  = ddc_pkg::YEAR_OUT_W'(ddc_pkg::EPOCH_YEAR) +
                            ddc_pkg::YEAR_OUT_W'(r_a.yoff);
            n_b.month_out = r_a.month;
            n_b.day_out   = ddc_pkg::DAY_W'(r_a.rem - r_a.mstart + ddc_pkg::REM_W'(1));
        end else if (r_a.ok) begin
            n_b.valid_res = 1'b1;
            n_b.days_out  = r_a.total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (w_ready_a) begin
                r_vld_a <= i_valid;
            end
            if (w_ready_b) begin
                r_vld_b <= r_vld_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_valid) begin
            r_a <= n_a;
        end
        if (w_ready_b && r_vld_a) begin
            r_b <= n_b;
        end
    end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for date_day_count_converter_core
// Streams dates and day counts through the converter with random gaps on the
// slave side and random stalls on the master side. Every result transaction
// is compared field by field against a behavioral calendar model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int          COUNT_BITS   = ddc_pkg::COUNT_BITS_DEF;
    localparam int unsigned COUNT_MASK   = (1 << COUNT_BITS) - 1;
    localparam int          RANDOM_ITEMS = 1650;
    localparam int          MAX_WAIT     = 18;
    // Longest honest silence is a sender gap plus a receiver stall plus the
    // five-stage pipeline; the limit leaves a wide margin over that.
    localparam int          IDLE_LIMIT   = 400;
    localparam int          DRAIN_CYCLES = 20;

    // One request transaction and the idle cycles the sender waits before it.
    typedef struct {
        ddc_pkg::t_mode             mode;
        logic [ddc_pkg::YEAR_W-1:0] year;
        logic [ddc_pkg::MD_W-1:0]   month;
        logic [ddc_pkg::MD_W-1:0]   day;
        logic [ddc_pkg::CNT_W-1:0]  count;
        int unsigned                gap;
    } t_date_req;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;

    t_date_req     pending_q[$];
    ddc_pkg::t_res expected_q[$];
    logic          req_taken;
    logic          res_taken;
    int unsigned   gap_left;
    int unsigned   stall_left;
    int unsigned   requests_total;
    int unsigned   requests_accepted;
    int unsigned   results_seen;
    int unsigned   idle_cycles;
    int unsigned   error_count;

    date_day_count_converter_core #(
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Calendar model
    // ------------------------------------------------------------------------
    function automatic bit is_leap(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int unsigned year_length(input int unsigned y);
        return is_leap(y) ? 366 : 365;
    endfunction

    function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
        case (m)
            2:          return is_leap(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:    return 31;
        endcase
    endfunction

    // Expected result transaction for one request.
    function automatic ddc_pkg::t_res convert_date(input t_date_req r);
        ddc_pkg::t_res res;
        int unsigned   y;
        int unsigned   m;
        int unsigned   total;
        int unsigned   rest;
        res = '0;
        if (r.mode == ddc_pkg::MODE_TO_COUNT) begin
            if (r.year >= ddc_pkg::EPOCH_YEAR && r.year <= ddc_pkg::LAST_YEAR &&
                r.month >= 1 && r.month <= 12 &&
                r.day >= 1 && r.day <= month_length(r.year, r.month)) begin
                total = 0;
                for (y = ddc_pkg::EPOCH_YEAR; y < r.year; y++) begin
                    total += year_length(y);
                end
                for (m = 1; m < r.month; m++) begin
                    total += month_length(r.year, m);
                end
                total += r.day - 1;
                res.valid_res = 1'b1;
                res.days_out  = ddc_pkg::CNT_W'(total & COUNT_MASK);
            end
        end else begin
            // No range check in this direction: every count maps to a date.
            rest = r.count & COUNT_MASK;
            y    = ddc_pkg::EPOCH_YEAR;
            m    = 1;
            while (rest >= year_length(y)) begin
                rest -= year_length(y);
                y++;
            end
            while (m < 12 && rest >= month_length(y, m)) begin
                rest -= month_length(y, m);
                m++;
            end
            res.valid_res = 1'b1;
            res.year_out  = ddc_pkg::YEAR_OUT_W'(y);
            res.month_out = ddc_pkg::MONTH_W'(m);
            res.day_out   = ddc_pkg::DAY_W'(rest + 1);
        end
        return res;
    endfunction

    // Waits come in stretches: none at all, fully random, or mostly none.
    function automatic int unsigned pick_wait(input int unsigned n);
        case ((n / 96) % 3)
            0:       return 0;
            1:       return $urandom_range(0, MAX_WAIT);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
        endcase
    endfunction

    task automatic queue_request(input ddc_pkg::t_mode mode, input int unsigned y,
                                 input int unsigned m, input int unsigned d,
                                 input int unsigned c);
        t_date_req req;
        req.mode  = mode;
        req.year  = ddc_pkg::YEAR_W'(y);
        req.month = ddc_pkg::MD_W'(m);
        req.day   = ddc_pkg::MD_W'(d);
        req.count = ddc_pkg::CNT_W'(c);
        req.gap   = pick_wait(pending_q.size());
        pending_q.push_back(req);
    endtask

    task automatic queue_date(input int unsigned y, input int unsigned m, input int unsigned d);
        queue_request(ddc_pkg::MODE_TO_COUNT, y, m, d, $urandom_range(0, 65535));
    endtask

    task automatic queue_count(input int unsigned c);
        queue_request(ddc_pkg::MODE_TO_DATE, $urandom_range(0, 16383), $urandom_range(0, 127),
                      $urandom_range(0, 127), c);
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns, result %0d: %s", $time, results_seen, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Slave-side driver: presents queued requests, holding each until taken.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_date_req req;
        logic      drive;
        drive = i_s_axis_tvalid;
        if (drive && req_taken) begin
            drive    = 1'b0;
            gap_left = (pending_q.size() > 0) ? pending_q[0].gap : 0;
        end
        if (!drive && i_rst_n && pending_q.size() > 0) begin
            if (gap_left > 0) begin
                gap_left--;
            end else begin
                req   = pending_q.pop_front();
                drive = 1'b1;
                i_s_axis_tuser <= req.mode;
                i_s_axis_tdata <= {4'b0, req.count, req.day, req.month, req.year};
            end
        end
        i_s_axis_tvalid <= drive;
    end

    // Master-side ready: after each result transaction, stall for a drawn time.
    always @(negedge i_clk) begin
        if (res_taken) begin
            stall_left = pick_wait(results_seen);
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on accepted requests, checks accepted results.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_date_req     req;
        ddc_pkg::t_res got;
        ddc_pkg::t_res want;
        logic          in_fire;
        logic          out_fire;
        in_fire  = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        out_fire = i_rst_n && o_m_axis_tvalid && i_m_axis_tready;
        req_taken <= in_fire;
        res_taken <= out_fire;

        if (in_fire) begin
            req.mode  = ddc_pkg::t_mode'(i_s_axis_tuser);
            req.year  = i_s_axis_tdata[13:0];
            req.month = i_s_axis_tdata[20:14];
            req.day   = i_s_axis_tdata[27:21];
            req.count = i_s_axis_tdata[43:28];
            req.gap   = 0;
            expected_q.push_back(convert_date(req));
            requests_accepted++;
        end

        if (out_fire) begin
            got.valid_res = o_m_axis_tuser;
            got.days_out  = o_m_axis_tdata[15:0];
            got.year_out  = o_m_axis_tdata[27:16];
            got.month_out = o_m_axis_tdata[31:28];
            got.day_out   = o_m_axis_tdata[36:32];
            if (expected_q.size() == 0) begin
                report_mismatch("result transaction with no request pending");
            end else begin
                want = expected_q.pop_front();
                if (got.valid_res !== want.valid_res)
                    report_mismatch($sformatf("valid_res got %0d want %0d",
                                              got.valid_res, want.valid_res));
                if (got.days_out !== want.days_out)
                    report_mismatch($sformatf("days_out got %0d want %0d",
                                              got.days_out, want.days_out));
                if (got.year_out !== want.year_out)
                    report_mismatch($sformatf("year_out got %0d want %0d",
                                              got.year_out, want.year_out));
                if (got.month_out !== want.month_out)
                    report_mismatch($sformatf("month_out got %0d want %0d",
                                              got.month_out, want.month_out));
                if (got.day_out !== want.day_out)
                    report_mismatch($sformatf("day_out got %0d want %0d",
                                              got.day_out, want.day_out));
            end
            results_seen++;
        end

        // Watchdog: a long stretch with no transaction on either side is a hang.
        if (in_fire || out_fire || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned n;
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned pick;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_s_axis_tvalid   = 1'b0;
        i_s_axis_tdata    = '0;
        i_s_axis_tuser    = 1'b0;
        i_m_axis_tready   = 1'b0;
        req_taken         = 1'b0;
        res_taken         = 1'b0;
        gap_left          = 0;
        stall_left        = 0;
        requests_accepted = 0;
        results_seen      = 0;
        idle_cycles       = 0;
        error_count       = 0;

        // Directed dates: range edges, leap rules and malformed fields.
        queue_date(1970, 1, 1);
        queue_date(2038, 12, 31);
        queue_date(1969, 12, 31);
        queue_date(2039, 1, 1);
        queue_date(2000, 2, 29);
        queue_date(2001, 2, 29);
        queue_date(2004, 2, 29);
        queue_date(2024, 2, 30);
        queue_date(1999, 4, 31);
        queue_date(2038, 1, 19);
        queue_date(2010, 0, 15);
        queue_date(2010, 13, 15);
        queue_date(2010, 6, 0);
        queue_date(16383, 127, 127);
        queue_date(0, 0, 0);
        // Directed counts: zero, leap day, the skipped leap year 2100, full scale.
        queue_count(0);
        queue_count(59);
        queue_count(789);
        queue_count(24855);
        queue_count(25201);
        queue_count(47481);
        queue_count(47540);
        queue_count(47541);
        queue_count(65535);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                // Well-formed date, often pinned to the last day of its month.
                y = $urandom_range(ddc_pkg::EPOCH_YEAR, ddc_pkg::LAST_YEAR);
                m = $urandom_range(1, 12);
                d = ($urandom_range(0, 3) == 0) ? month_length(y, m)
                                                : $urandom_range(1, month_length(y, m));
                queue_date(y, m, d);
            end else if (pick < 42) begin
                // One day past the end of the month.
                y = $urandom_range(ddc_pkg::EPOCH_YEAR, ddc_pkg::LAST_YEAR);
                m = $urandom_range(1, 12);
                queue_date(y, m, month_length(y, m) + 1);
            end else if (pick < 48) begin
                queue_date($urandom_range(1965, 2043), $urandom_range(0, 13),
                           $urandom_range(0, 32));
            end else if (pick < 53) begin
                queue_date($urandom_range(0, 16383), $urandom_range(0, 127),
                           $urandom_range(0, 127));
            end else if (pick < 78) begin
                queue_count($urandom_range(0, 25201));
            end else if (pick < 85) begin
                queue_count($urandom_range(47300, 47900));
            end else begin
                queue_count($urandom_range(0, 65535));
            end
        end
        requests_total = pending_q.size();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_accepted < requests_total || expected_q.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
